// ===== hdl/msir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msir_pkg: shared types and codes for the identifier remapper
// Result status codes and scan states.
// ----------------------------------------------------------------------------
package msir_pkg;

  typedef enum logic [2:0] {
    ST_EXISTING  = 3'd0,
    ST_KEPT      = 3'd1,
    ST_RENAMED   = 3'd2,
    ST_FULL      = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_USED,
    S_DECIDE,
    S_OUT
  } back_state_t;

endpackage

// ===== hdl/multi_source_id_remapper_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_source_id_remapper_unit: multi-source identifier remapper
// Maps (source, identifier) pairs to globally unique identifiers.
// ----------------------------------------------------------------------------
// channel | handshake          | fields
// in      | in_valid/in_stall  | source, track_ident
// out     | out_valid/out_stall| mapped_ident, status
// Each transaction walks the mapping memory one entry per cycle, then checks
// the used map, decides and presents the result.
// After reset a clearing pass wipes every entry of the used map; no
// transaction is processed until it ends (the two-deep queue takes up to two).
// Output stall holds the result; the input queue accepts until its two
// entries are full, then stalls the input.
// ----------------------------------------------------------------------------
module multi_source_id_remapper_unit #(
  parameter int SOURCES     = 8,
  parameter int ID_BITS     = 16,
  parameter int MAP_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  source,
  input  logic [15:0] track_ident,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] mapped_ident,
  output logic [2:0]  status
);
  import msir_pkg::*;

  localparam int SRC_W = SOURCES > 1 ? $clog2(SOURCES) : 1;

  logic               q_valid, q_pop;
  logic [SRC_W-1:0]   q_src;
  logic [ID_BITS-1:0] q_id;

  msir_front #(.SOURCES(SOURCES), .ID_BITS(ID_BITS), .SRC_W(SRC_W)) u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .source, .track_ident,
    .q_valid, .q_pop, .q_src, .q_id
  );

  msir_back #(.ID_BITS(ID_BITS), .MAP_ENTRIES(MAP_ENTRIES), .SRC_W(SRC_W)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_src, .q_id,
    .out_valid, .out_stall, .mapped_ident, .status
  );

endmodule

// ===== hdl/msir_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msir_front: input classification and request queue
// Folds source and identifier to their ranges and queues them for the back.
// ----------------------------------------------------------------------------
module msir_front #(
  parameter int SOURCES = 8,
  parameter int ID_BITS = 16,
  parameter int SRC_W   = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               stall,
  input  logic [2:0]         source,
  input  logic [15:0]        track_ident,
  output logic               q_valid,
  input  logic               q_pop,
  output logic [SRC_W-1:0]   q_src,
  output logic [ID_BITS-1:0] q_id
);
  import msir_pkg::*;

  localparam int IW = ID_BITS > 16 ? ID_BITS : 16;

  logic [SRC_W-1:0]   src_f;
  logic [IW-1:0]      id_wide;
  logic [SRC_W-1:0]   qs [2];
  logic [ID_BITS-1:0] qi [2];
  logic               wp, rp;
  logic [1:0]         cnt;
  logic               push;

  // fold source into range: eight-way select, remainder taken on loop constants
  always_comb begin
    src_f = '0;
    for (int k = 0; k < 8; k++) begin
      if (source == 3'(k)) src_f = SRC_W'(k % SOURCES);
    end
    id_wide = IW'(track_ident);
  end

  assign stall   = (cnt == 2'd2);
  assign push    = valid && !stall;
  assign q_valid = (cnt != 2'd0);
  assign q_src   = qs[rp];
  assign q_id    = qi[rp];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        qs[wp] <= src_f;
        qi[wp] <= id_wide[ID_BITS-1:0];
        wp     <= ~wp;
      end
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== hdl/msir_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msir_back: table scan, used-map check and mapping update
// Walks the mapping memory one entry per cycle, then reads the used bit, decides and commits any new mapping.
// ----------------------------------------------------------------------------
module msir_back #(
  parameter int ID_BITS     = 16,
  parameter int MAP_ENTRIES = 256,
  parameter int SRC_W       = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  logic [SRC_W-1:0]   q_src,
  input  logic [ID_BITS-1:0] q_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        mapped_ident,
  output logic [2:0]         status
);
  import msir_pkg::*;

  localparam int AW   = $clog2(MAP_ENTRIES);
  localparam int CW   = AW + 1;
  localparam int EW   = SRC_W + 2 * ID_BITS;
  localparam int USED = 1 << ID_BITS;
  localparam int OW   = ID_BITS > 16 ? ID_BITS : 16;
  localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};

  logic [EW-1:0]      tbl [MAP_ENTRIES];
  logic               used_mem [USED];
  back_state_t        state, state_next;
  logic [CW-1:0]      entry_count;
  logic [CW-1:0]      idx;
  logic [ID_BITS-1:0] clr_idx;
  logic [ID_BITS-1:0] highest;
  logic [EW-1:0]      rd_entry;
  logic               rd_used;
  logic               found;
  logic [ID_BITS-1:0] found_map;
  logic [ID_BITS-1:0] res_map;
  status_t            res_st;
  logic [ID_BITS-1:0] dec_map;
  status_t            dec_st;
  logic               commit;
  logic               rd_live;
  logic [OW-1:0]      map_wide;

  // entry read is registered; rd_live marks a valid read in flight
  always_ff @(posedge clk) begin
    rd_entry <= tbl[idx[AW-1:0]];
    rd_used  <= used_mem[q_id];
    if (commit) tbl[entry_count[AW-1:0]] <= {q_src, q_id, dec_map};
    if (state == S_CLEAR) used_mem[clr_idx] <= 1'b0;
    else if (commit) used_mem[dec_map] <= 1'b1;
  end

  // decision from scan result and used bit
  always_comb begin
    dec_map = '0;
    dec_st  = ST_EXISTING;
    if (found) begin
      dec_map = found_map;
    end else if (entry_count == CW'(MAP_ENTRIES)) begin
      dec_st = ST_FULL;
    end else if (!rd_used) begin
      dec_map = q_id;
      dec_st  = ST_KEPT;
    end else if (highest == ID_MAX) begin
      dec_st = ST_EXHAUSTED;
    end else begin
      dec_map = highest + 1'b1;
      dec_st  = ST_RENAMED;
    end
  end

  assign commit = (state == S_DECIDE) && (dec_st == ST_KEPT || dec_st == ST_RENAMED);

  // next state
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      S_CLEAR:  if (clr_idx == ID_MAX) state_next = S_IDLE;
      S_IDLE:   if (q_valid) state_next = S_SCAN;
      S_SCAN:   if (found || (idx >= entry_count && !rd_live)) state_next = S_USED;
      S_USED:   state_next = S_DECIDE;
      S_DECIDE: state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          q_pop      = 1'b1;
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      entry_count <= '0;
      highest     <= '0;
      idx         <= '0;
      rd_live     <= 1'b0;
      found       <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr_idx <= clr_idx + 1'b1;
        S_IDLE: begin
          idx     <= '0;
          rd_live <= 1'b0;
          found   <= 1'b0;
        end
        S_SCAN: begin
          // compare the entry read last cycle
          if (rd_live && !found &&
              rd_entry[EW-1:2*ID_BITS] == q_src &&
              rd_entry[2*ID_BITS-1:ID_BITS] == q_id) begin
            found     <= 1'b1;
            found_map <= rd_entry[ID_BITS-1:0];
          end
          rd_live <= (idx < entry_count);
          if (idx < entry_count) idx <= idx + 1'b1;
        end
        S_DECIDE: begin
          res_map <= dec_map;
          res_st  <= dec_st;
          if (commit) begin
            entry_count <= entry_count + 1'b1;
            if (dec_map > highest) highest <= dec_map;
          end
        end
        default: ;
      endcase
    end
  end

  assign map_wide     = OW'(res_map);
  assign out_valid    = (state == S_OUT);
  assign mapped_ident = map_wide[15:0];
  assign status       = res_st;

endmodule

// ===== hdl/msir_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msir_checker: port-level checks for the remapper
// Watches handshakes and result codes over time.
// ----------------------------------------------------------------------------
module msir_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] mapped_ident,
  input logic [2:0]  status
);
  import msir_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mapped_ident) && $stable(status))
    else $error("stalled result changed");

  // status is a defined code
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_EXISTING || status == ST_KEPT || status == ST_RENAMED ||
                  status == ST_FULL || status == ST_EXHAUSTED)
    else $error("bad status");

  // errors carry a zero identifier
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_EXHAUSTED) |-> mapped_ident == 16'd0)
    else $error("error result nonzero");

  // no result right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");

endmodule

bind multi_source_id_remapper_unit msir_checker u_msir_checker (
  .clk, .rst, .out_valid, .out_stall, .mapped_ident, .status
);
